>>> rtl/assert_macros.svh
// Assertion macros shared by the sort engine RTL.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked property, ignored while reset is asserted
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Clocked property, checked through reset as well
`define SSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/ssort_pkg.sv
// Constants and types for the selection sort engine.
// No dependencies; imported by the top level.
package ssort_pkg;

    localparam int DEPTH       = 64;
    localparam int STORE_SLOTS = 64;
    localparam int CAP         = (DEPTH < STORE_SLOTS) ? DEPTH : STORE_SLOTS;
    localparam int ADDR_W      = $clog2(STORE_SLOTS);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int ELEM_W      = 32;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SCAN,
        ST_SWAP1,
        ST_SWAP2,
        ST_EMIT
    } t_state;

endpackage

>>> rtl/ssort_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ssort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/selection_sort_engine_core.sv
// Load, sort and emit: 1 element per cycle in while o_in_ready is high, ascending run out;
// a result is read only once the previous read has reached the output register, and that
// register is free or taken. A sort pass scans one store entry per cycle, then swaps in
// ST_SWAP1 and ST_SWAP2. o_in_ready is low from the closing transfer until the last
// result has been read from the store.
// Reset (synchronous, active low) clears count, overflow flag and control; store not cleared.
`include "assert_macros.svh"

module selection_sort_engine_core
    import ssort_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_last_element,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [ELEM_W-1:0] o_sorted_value,
    output logic                     o_run_end,
    output logic                     o_truncated
);

    t_state r_state, n_state;
    t_cnt   r_count, n_count;
    logic   r_ovf, n_ovf;
    t_addr  r_i, n_i;
    t_cnt   r_j, n_j;
    t_cnt   r_k, n_k;
    logic   r_scan_vld, n_scan_vld;
    t_addr  r_scan_idx, n_scan_idx;
    t_addr  r_pick, n_pick;
    logic signed [ELEM_W-1:0] r_min, n_min;
    logic [ELEM_W-1:0]        r_vi, n_vi;
    logic   r_pend, n_pend;
    logic   r_pend_end, n_pend_end;
    logic   r_pend_trunc, n_pend_trunc;
    logic   r_out_vld, n_out_vld;
    logic [ELEM_W-1:0] r_out_data, n_out_data;
    logic   r_out_end, n_out_end;
    logic   r_out_trunc, n_out_trunc;

    logic              ram_we;
    t_addr             ram_waddr;
    logic [ELEM_W-1:0] ram_wdata;
    logic              ram_re;
    t_addr             ram_raddr;
    logic [ELEM_W-1:0] ram_rdata;

    logic in_fire;
    logic room;
    t_cnt load_cnt;
    logic emit_go;
    logic emit_last;
    t_cnt pick_ext;

    ssort_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (STORE_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == ST_LOAD);
    assign in_fire    = i_in_valid && o_in_ready;
    assign room       = (r_count < t_cnt'(CAP));
    assign load_cnt   = room ? (r_count + t_cnt'(1)) : r_count;
    // only one read in flight, and only into an output register that is free next cycle
    assign emit_go    = (r_state == ST_EMIT) && !r_pend && (!r_out_vld || i_out_ready);
    assign emit_last  = ((r_k + t_cnt'(1)) == r_count);
    assign pick_ext   = {1'b0, r_pick};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_i          = r_i;
        n_j          = r_j;
        n_k          = r_k;
        n_scan_vld   = 1'b0;
        n_scan_idx   = r_scan_idx;
        n_pick       = r_pick;
        n_min        = r_min;
        n_vi         = r_vi;
        n_pend       = 1'b0;
        n_pend_end   = r_pend_end;
        n_pend_trunc = r_pend_trunc;
        ram_we       = 1'b0;
        ram_waddr    = r_count[ADDR_W-1:0];
        ram_wdata    = i_element_value;
        ram_re       = 1'b0;
        ram_raddr    = r_j[ADDR_W-1:0];

        unique case (r_state)
            ST_LOAD: begin
                if (in_fire) begin
                    if (room) begin
                        ram_we  = 1'b1;
                        n_count = load_cnt;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last_element) begin
                        n_i = '0;
                        n_j = '0;
                        n_k = '0;
                        n_state = (load_cnt >= t_cnt'(2)) ? ST_SCAN : ST_EMIT;
                    end
                end
            end
            ST_SCAN: begin
                if (r_j < r_count) begin
                    ram_re     = 1'b1;
                    n_j        = r_j + t_cnt'(1);
                    n_scan_vld = 1'b1;
                    n_scan_idx = r_j[ADDR_W-1:0];
                end
                if (r_scan_vld) begin
                    if (r_scan_idx == r_i) begin
                        n_min  = $signed(ram_rdata);
                        n_vi   = ram_rdata;
                        n_pick = r_i;
                    end else if ($signed(ram_rdata) < r_min) begin
                        // strict compare keeps the first minimum
                        n_min  = $signed(ram_rdata);
                        n_pick = r_scan_idx;
                    end
                    if ({1'b0, r_scan_idx} == (r_count - t_cnt'(1))) begin
                        n_state = ST_SWAP1;
                    end
                end
            end
            ST_SWAP1: begin
                ram_we    = 1'b1;
                ram_waddr = r_pick;
                ram_wdata = r_vi;
                n_state   = ST_SWAP2;
            end
            ST_SWAP2: begin
                ram_we    = 1'b1;
                ram_waddr = r_i;
                ram_wdata = r_min;
                n_i       = r_i + t_addr'(1);
                if (({1'b0, r_i} + t_cnt'(2)) < r_count) begin
                    n_j     = {1'b0, r_i} + t_cnt'(1);
                    n_state = ST_SCAN;
                end else begin
                    n_k     = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                ram_raddr = r_k[ADDR_W-1:0];
                if (emit_go) begin
                    ram_re       = 1'b1;
                    n_pend       = 1'b1;
                    n_pend_end   = emit_last;
                    n_pend_trunc = r_ovf;
                    n_k          = r_k + t_cnt'(1);
                    if (emit_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = ST_LOAD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // output register, loaded from the store read data in the cycle after the read is issued
    always_comb begin
        n_out_vld   = r_out_vld;
        n_out_data  = r_out_data;
        n_out_end   = r_out_end;
        n_out_trunc = r_out_trunc;
        if (r_pend) begin
            n_out_vld   = 1'b1;
            n_out_data  = ram_rdata;
            n_out_end   = r_pend_end;
            n_out_trunc = r_pend_trunc;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_LOAD;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
            r_scan_vld <= 1'b0;
            r_pend     <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_ovf      <= n_ovf;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
            r_scan_vld <= n_scan_vld;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_idx   <= n_scan_idx;
        r_pick       <= n_pick;
        r_min        <= n_min;
        r_vi         <= n_vi;
        r_pend_end   <= n_pend_end;
        r_pend_trunc <= n_pend_trunc;
        r_out_data   <= n_out_data;
        r_out_end    <= n_out_end;
        r_out_trunc  <= n_out_trunc;
    end

    assign o_out_valid    = r_out_vld;
    assign o_sorted_value = $signed(r_out_data);
    assign o_run_end      = r_out_end;
    assign o_truncated    = r_out_trunc;

    `SSE_ASSERT(a_pend_into_free_slot, i_clk, i_rst_n, r_pend |-> !r_out_vld, "read data would overwrite a pending result")
    `SSE_ASSERT(a_scan_no_write, i_clk, i_rst_n, (r_state == ST_SCAN) |-> !ram_we, "store written during minimum scan")
    `SSE_ASSERT(a_pick_in_range, i_clk, i_rst_n, (r_state == ST_SWAP1) |-> (pick_ext < r_count), "swap index beyond stored count")
    `SSE_ASSERT(a_run_clears, i_clk, i_rst_n, (emit_go && emit_last) |=> ((r_count == '0) && !r_ovf && r_pend && r_pend_end), "count or flag not cleared after final read")

endmodule
